### sv/acs_pkg.sv
// Shared types, constants and codec check functions for the A2DP capability selector.
package acs_pkg;

  typedef enum logic [1:0] {
    PH_CATEGORY,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    REG_CODEC_TYPE,
    REG_REQ_RATE,
    REG_AAC_MIN,
    REG_AAC_MAX
  } reg_idx_t;

  localparam int RATE_W = 23;

  localparam logic [7:0] CODEC_SBC  = 8'h00;
  localparam logic [7:0] CODEC_AAC  = 8'h02;
  localparam logic [7:0] CODEC_LDAC = 8'hff;

  localparam logic [7:0] CAT_TRANSPORT = 8'd1;
  localparam logic [7:0] CAT_CODEC     = 8'd7;

  localparam logic [7:0] LEN_SBC  = 8'd6;
  localparam logic [7:0] LEN_AAC  = 8'd8;
  localparam logic [7:0] LEN_LDAC = 8'd10;

  localparam logic [3:0] SIZE_SBC  = 4'd4;
  localparam logic [3:0] SIZE_AAC  = 4'd6;
  localparam logic [3:0] SIZE_LDAC = 4'd8;

  localparam logic [7:0] SBC_MASK0    = 8'h11;
  localparam logic [7:0] SBC_MASK1    = 8'h15;
  localparam logic [7:0] SBC_BP_MIN   = 8'd2;
  localparam logic [7:0] SBC_BP_MAX   = 8'd53;
  localparam int         SBC_RATE_BASE = 39000;
  localparam int         SBC_RATE_STEP = 6000;
  localparam int         SBC_RATE_OFS  = 36000;

  localparam logic [7:0] AAC_OBJ_MASK  = 8'hc0;
  localparam logic [7:0] AAC_OBJ_LC    = 8'h40;
  localparam logic [7:0] AAC_OBJ_OTHER = 8'h80;
  localparam logic [7:0] AAC_FREQ_MASK = 8'h84;
  localparam logic [7:0] AAC_VBR_BIT   = 8'h80;

  localparam logic [7:0] LDAC_B0 = 8'h2d;
  localparam logic [7:0] LDAC_B1 = 8'h01;
  localparam logic [7:0] LDAC_B4 = 8'haa;
  localparam logic [7:0] LDAC_B6 = 8'h10;
  localparam logic [7:0] LDAC_B7 = 8'h01;

  localparam logic [7:0]        CODEC_TYPE_RST = 8'h00;
  localparam int                REQ_RATE_RST   = 328000;
  localparam logic [RATE_W-1:0] AAC_MIN_RST    = 23'd64000;
  localparam logic [RATE_W-1:0] AAC_MAX_RST    = 23'd320000;

  // bitpool = floor((rate - 36000) / 6000) = floor(((rate - 36000) >> 4) / 375)
  localparam int          BP_SHIFT  = 4;
  localparam int          BP_DIVQ   = 375;
  localparam int          BP_FRAC   = 29;
  localparam int          BP_Y_W    = RATE_W - BP_SHIFT;
  localparam int          BP_M_W    = 21;
  localparam int          BP_PROD_W = BP_Y_W + BP_M_W;
  localparam int          BP_Q_W    = BP_PROD_W - BP_FRAC;
  localparam logic [BP_M_W-1:0] BP_RECIP =
    BP_M_W'(((64'd1 << BP_FRAC) + 64'(BP_DIVQ) - 64'd1) / 64'(BP_DIVQ));
  localparam logic [BP_PROD_W-1:0] BP_PROD_RST =
    BP_PROD_W'(64'((REQ_RATE_RST - SBC_RATE_OFS) >> BP_SHIFT) * 64'(BP_RECIP));

  typedef logic [7:0] byte_t;
  typedef byte_t [7:0] info_t;

  typedef struct packed {
    logic [7:0] cap_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [3:0]        config_size;
    logic [RATE_W-1:0] bit_rate;
    logic [7:0]        cfg_byte0;
    logic [7:0]        cfg_byte1;
    logic [7:0]        cfg_byte2;
    logic [7:0]        cfg_byte3;
    logic [7:0]        cfg_byte4;
    logic [7:0]        cfg_byte5;
    logic [7:0]        cfg_byte6;
    logic [7:0]        cfg_byte7;
  } out_t;

  typedef struct packed {
    logic [7:0]           codec_type;
    logic [RATE_W-1:0]    req_rate;
    logic [RATE_W-1:0]    aac_min;
    logic [RATE_W-1:0]    aac_max;
    logic                 bp_low;
    logic [BP_PROD_W-1:0] bp_prod;
  } cfg_t;

  typedef struct packed {
    logic  list_ok;
    info_t info;
  } snap_t;

  function automatic logic [7:0] codec_entry_len(input logic [7:0] ct);
    logic [7:0] len;
    case (ct)
      CODEC_SBC:  len = LEN_SBC;
      CODEC_AAC:  len = LEN_AAC;
      CODEC_LDAC: len = LEN_LDAC;
      default:    len = 8'd0;
    endcase
    return len;
  endfunction

  function automatic logic codec_check(input logic [7:0] ct, input info_t d);
    logic ok;
    case (ct)
      CODEC_SBC: begin
        ok = ((d[0] & SBC_MASK0) == SBC_MASK0) && ((d[1] & SBC_MASK1) == SBC_MASK1) &&
             (d[2] >= SBC_BP_MIN) && (d[2] <= d[3]) && (d[2] <= SBC_BP_MAX);
      end
      CODEC_AAC: begin
        ok = ((d[0] & AAC_OBJ_MASK) != 8'd0) &&
             ((d[2] & AAC_FREQ_MASK) == AAC_FREQ_MASK) &&
             ((d[3] & AAC_VBR_BIT) != 8'd0);
      end
      CODEC_LDAC: begin
        ok = (d[0] == LDAC_B0) && (d[1] == LDAC_B1) && (d[2] == 8'd0) &&
             (d[3] == 8'd0) && (d[4] == LDAC_B4) && (d[5] == 8'd0) &&
             ((d[6] & LDAC_B6) != 8'd0) && ((d[7] & LDAC_B7) != 8'd0);
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### sv/acs_cfg_regs.sv
// Configuration registers and the registered SBC bitpool reciprocal product.
module acs_cfg_regs
  import acs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [RATE_W-1:0] cfg_wdata,
  output cfg_t        cfg
);

  logic [7:0]           codec_type_r;
  logic [RATE_W-1:0]    req_rate_r;
  logic [RATE_W-1:0]    aac_min_r;
  logic [RATE_W-1:0]    aac_max_r;
  logic                 bp_low_r;
  logic [BP_PROD_W-1:0] bp_prod_r;
  logic                 bp_low_nxt;
  logic [BP_PROD_W-1:0] bp_prod_nxt;
  logic [RATE_W-1:0]    rate_ofs;
  logic [BP_Y_W-1:0]    rate_y;
  logic                 wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_type_r <= CODEC_TYPE_RST;
      req_rate_r   <= RATE_W'(REQ_RATE_RST);
      aac_min_r    <= AAC_MIN_RST;
      aac_max_r    <= AAC_MAX_RST;
    end else if (wr) begin
      case (reg_idx_t'(cfg_index))
        REG_CODEC_TYPE: codec_type_r <= cfg_wdata[7:0];
        REG_REQ_RATE:   req_rate_r   <= cfg_wdata;
        REG_AAC_MIN:    aac_min_r    <= cfg_wdata;
        REG_AAC_MAX:    aac_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    bp_low_nxt  = req_rate_r <= RATE_W'(SBC_RATE_BASE);
    rate_ofs    = req_rate_r - RATE_W'(SBC_RATE_OFS);
    rate_y      = rate_ofs[RATE_W-1:BP_SHIFT];
    bp_prod_nxt = BP_PROD_W'(rate_y) * BP_PROD_W'(BP_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_low_r  <= 1'b0;
      bp_prod_r <= BP_PROD_RST;
    end else begin
      bp_low_r  <= bp_low_nxt;
      bp_prod_r <= bp_prod_nxt;
    end
  end

  assign cfg = '{codec_type: codec_type_r, req_rate: req_rate_r, aac_min: aac_min_r,
                 aac_max: aac_max_r, bp_low: bp_low_r, bp_prod: bp_prod_r};

endmodule

### sv/acs_parser.sv
// Input register, capability list parser and end-of-list snapshot register.
module acs_parser
  import acs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  cfg_t  cfg,
  input  logic  out_free,
  output logic  snap_valid,
  output snap_t snap
);

  logic       in_vld_r;
  in_t        in_word_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] cat_r, cat_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic       transport_r, transport_nxt;
  logic       found_r, found_nxt;
  logic       failed_r, failed_nxt;
  info_t      info_r, info_nxt;
  logic       snap_vld_r;
  snap_t      snap_r;
  logic       snap_free;
  logic       fire;
  logic       bad;
  logic [7:0] b;
  logic [7:0] want;
  logic [7:0] slot;
  logic       list_ok;

  assign snap_free = !snap_vld_r || out_free;
  assign fire      = in_vld_r && (!in_word_r.last_byte || snap_free);
  assign in_stall  = in_vld_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_data;
    end
  end

  always_comb begin
    b             = in_word_r.cap_byte;
    want          = codec_entry_len(cfg.codec_type);
    slot          = idx_r - 8'd2;
    bad           = 1'b0;
    phase_nxt     = phase_r;
    cat_nxt       = cat_r;
    left_nxt      = left_r;
    idx_nxt       = idx_r;
    transport_nxt = transport_r;
    found_nxt     = found_r;
    failed_nxt    = failed_r;
    info_nxt      = info_r;
    if (!failed_r) begin
      case (phase_r)
        PH_CATEGORY: begin
          cat_nxt   = b;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          left_nxt = b;
          idx_nxt  = 8'd0;
          if (cat_r == CAT_TRANSPORT) begin
            if (transport_r || b != 8'd0) begin
              bad = 1'b1;
            end else begin
              transport_nxt = 1'b1;
            end
          end else if (cat_r == CAT_CODEC) begin
            if (found_r || want == 8'd0 || b != want) begin
              bad = 1'b1;
            end
          end
          if (bad) begin
            failed_nxt = 1'b1;
          end else begin
            phase_nxt = (b == 8'd0) ? PH_CATEGORY : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cat_r == CAT_CODEC) begin
            if (idx_r == 8'd0 && b != 8'd0) bad = 1'b1;
            if (idx_r == 8'd1 && b != cfg.codec_type) bad = 1'b1;
            if (idx_r inside {[8'd2:8'd9]}) info_nxt[slot[2:0]] = b;
          end
          if (bad) begin
            failed_nxt = 1'b1;
          end else begin
            idx_nxt  = idx_r + 8'd1;
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CATEGORY;
              if (cat_r == CAT_CODEC) begin
                if (codec_check(cfg.codec_type, info_nxt)) begin
                  found_nxt = 1'b1;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    list_ok = !failed_nxt && phase_nxt == PH_CATEGORY && transport_nxt && found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CATEGORY;
      cat_r       <= 8'd0;
      left_r      <= 8'd0;
      idx_r       <= 8'd0;
      transport_r <= 1'b0;
      found_r     <= 1'b0;
      failed_r    <= 1'b0;
    end else if (fire) begin
      if (in_word_r.last_byte) begin
        phase_r     <= PH_CATEGORY;
        cat_r       <= 8'd0;
        left_r      <= 8'd0;
        idx_r       <= 8'd0;
        transport_r <= 1'b0;
        found_r     <= 1'b0;
        failed_r    <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        cat_r       <= cat_nxt;
        left_r      <= left_nxt;
        idx_r       <= idx_nxt;
        transport_r <= transport_nxt;
        found_r     <= found_nxt;
        failed_r    <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      info_r <= info_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else if (fire && in_word_r.last_byte) begin
      snap_vld_r <= 1'b1;
    end else if (out_free) begin
      snap_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_word_r.last_byte) begin
      snap_r <= '{list_ok: list_ok, info: info_nxt};
    end
  end

  assign snap_valid = snap_vld_r;
  assign snap       = snap_r;

endmodule

### sv/acs_select.sv
// Codec configuration choice and the result output register.
module acs_select
  import acs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  snap_valid,
  input  snap_t snap,
  input  cfg_t  cfg,
  output logic  out_free,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  logic              out_vld_r;
  out_t              out_r;
  out_t              res;
  info_t             d;
  logic [BP_Q_W-1:0] bp;
  logic [5:0]        bp6;
  logic [RATE_W-1:0] r;
  logic [RATE_W-1:0] peak;
  logic              take;

  assign out_free = !out_vld_r || !out_stall;
  assign take     = snap_valid && out_free;

  always_comb begin
    d    = snap.info;
    res  = '0;
    bp   = cfg.bp_low ? BP_Q_W'(SBC_BP_MIN) : cfg.bp_prod[BP_PROD_W-1:BP_FRAC];
    if (bp < BP_Q_W'(d[2])) bp = BP_Q_W'(d[2]);
    if (bp > BP_Q_W'(d[3])) bp = BP_Q_W'(d[3]);
    if (bp > BP_Q_W'(SBC_BP_MAX)) bp = BP_Q_W'(SBC_BP_MAX);
    bp6  = bp[5:0];
    peak = {d[3][6:0], d[4], d[5]};
    r    = cfg.req_rate;
    if (r < cfg.aac_min) r = cfg.aac_min;
    if (r > cfg.aac_max) r = cfg.aac_max;
    if (peak != '0 && peak < r) r = peak;
    if (snap.list_ok && codec_check(cfg.codec_type, d)) begin
      res.accepted = 1'b1;
      case (cfg.codec_type)
        CODEC_SBC: begin
          res.config_size = SIZE_SBC;
          res.bit_rate    = RATE_W'(SBC_RATE_BASE) + RATE_W'(bp6) * RATE_W'(SBC_RATE_STEP);
          res.cfg_byte0   = SBC_MASK0;
          res.cfg_byte1   = SBC_MASK1;
          res.cfg_byte2   = {2'b00, bp6};
          res.cfg_byte3   = {2'b00, bp6};
        end
        CODEC_AAC: begin
          res.config_size = SIZE_AAC;
          res.bit_rate    = r;
          res.cfg_byte0   = d[0][6] ? AAC_OBJ_LC : AAC_OBJ_OTHER;
          res.cfg_byte2   = AAC_FREQ_MASK;
          res.cfg_byte3   = {1'b1, r[22:16]};
          res.cfg_byte4   = r[15:8];
          res.cfg_byte5   = r[7:0];
        end
        CODEC_LDAC: begin
          res.config_size = SIZE_LDAC;
          res.bit_rate    = cfg.req_rate;
          res.cfg_byte0   = LDAC_B0;
          res.cfg_byte1   = LDAC_B1;
          res.cfg_byte4   = LDAC_B4;
          res.cfg_byte6   = LDAC_B6;
          res.cfg_byte7   = LDAC_B7;
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### sv/a2dp_codec_capability_select.sv
// Top level of the A2DP codec capability selector.
//
// Feed a peer's capability list one word per cycle on in_data (cap_byte plus
// last_byte). A word is taken when in_valid is high and in_stall is low.
// Each list yields exactly one result word on out_data, delivered with
// out_valid after the word that carries last_byte; words that are not the
// last one yield nothing. The result holds the accept flag, the number of
// valid configuration bytes, the chosen bit rate and eight config bytes.
// The last word is taken into the input register, the parser loads the
// end-of-list snapshot, then the choice goes into the output register.
// Throughput is one word per cycle whenever in_stall is low, and the parser
// updates its state for each word that it accepts. While out_stall holds, the
// result waits in the output register, one more finished list waits in the
// snapshot register, and non-final words keep flowing; a further final word
// stalls the input. Configuration registers (codec type, requested rate, AAC
// limits) are written on the cfg channel, which is always ready; write them
// between lists. Synchronous reset clears the parser, empties the pipeline
// and loads the register defaults (SBC, 328000, 64000, 320000).
module a2dp_codec_capability_select
  import acs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [RATE_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  snap_t snap;
  logic  snap_valid;
  logic  out_free;

  acs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg),
    .out_free   (out_free),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  acs_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .cfg        (cfg),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_accept_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      (out_data.config_size == SIZE_SBC || out_data.config_size == SIZE_AAC ||
       out_data.config_size == SIZE_LDAC))
    else $error("accepted result with bad config size");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.config_size == 4'd0 && out_data.bit_rate == '0 && out_data.cfg_byte0 == 8'd0)
    else $error("rejected result carries nonzero fields");

  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && !out_free |=> snap_valid)
    else $error("pending list snapshot dropped while output stalled");
`endif

endmodule
